// ===== rtl/core/sliding_window_ac_rms_top_defines.svh =====
// ============================================================================
// Assertion macros used by the checker file swr_checker.sv
// ============================================================================
`ifndef SLIDING_WINDOW_AC_RMS_TOP_DEFINES_SVH
`define SLIDING_WINDOW_AC_RMS_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SWR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SWR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/swr_pkg.sv =====
// ============================================================================
// swr_pkg
// Shared types and constants of the sliding-window AC RMS block.
// ============================================================================
package swr_pkg;
  localparam int RmsW = 17;
  // Handshake between the top level and one channel lane.
  typedef struct packed {
    logic start;
    logic full;
  } swr_lane_ctl_t;
endpackage

// ===== rtl/core/swr_if.sv =====
// ============================================================================
// swr_if
// Valid/ready channel carrying a packed payload.
// ============================================================================
interface swr_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/swr_ram.sv =====
// ============================================================================
// swr_ram
// Generic single-port RAM with registered read.
// ============================================================================
module swr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/swr_lane.sv =====
// ============================================================================
// swr_lane
// One channel: running-sum update, variance, divide and square root.
// ============================================================================
module swr_lane import swr_pkg::*; #(
  parameter int SB   = 13,
  parameter int NW   = 8,
  parameter int S1W  = 21,
  parameter int S2W  = 34
) (
  input  logic          clk,
  input  logic          rst_n,
  input  swr_lane_ctl_t ctl,
  input  logic [SB-1:0] old_smp,
  input  logic [SB-1:0] new_smp,
  input  logic [NW:0]   n,
  output logic          done,
  output logic [RmsW-1:0] rms
);
  localparam int DW  = S2W + NW + 1;      // n*S2 width
  localparam int QW  = DW + 8;            // dividend width
  localparam int NNW = 2 * (NW + 1);
  localparam int RW  = (QW + 1) / 2;
  localparam int CW  = $clog2(QW + 2);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_UPD = 6'b000010, S_MUL = 6'b000100,
    S_DIV  = 6'b001000, S_SQ  = 6'b010000, S_OUT = 6'b100000
  } st_t;

  st_t st_r;
  logic [S1W-1:0] s1_r;
  logic [S2W-1:0] s2_r;
  logic [DW-1:0]  a_r, b_r;
  logic [NNW-1:0] nn_r;
  logic [QW-1:0]  num_r, quo_r;
  logic [NNW:0]   rem_r;
  logic [CW-1:0]  cnt_r;
  logic [QW-1:0]  x_r;
  logic [RW-1:0]  root_r;
  logic [RW+1:0]  srem_r;
  logic [RmsW-1:0] rms_r;

  logic [NNW:0]  rem_sh;
  logic [RW+1:0] srem_sh, strial;

  assign rem_sh  = {rem_r[NNW-1:0], num_r[QW-1]};
  assign srem_sh = {srem_r[RW-1:0], x_r[QW-1:QW-2]};
  assign strial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; s1_r <= '0; s2_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (ctl.start) st_r <= S_UPD;
        S_UPD: begin
          if (ctl.full) begin
            s1_r <= s1_r + S1W'(new_smp) - S1W'(old_smp);
            s2_r <= s2_r + S2W'(new_smp) * S2W'(new_smp) - S2W'(old_smp) * S2W'(old_smp);
          end else begin
            s1_r <= s1_r + S1W'(new_smp);
            s2_r <= s2_r + S2W'(new_smp) * S2W'(new_smp);
          end
          st_r <= S_MUL;
        end
        S_MUL: begin
          a_r  <= DW'(n) * DW'(s2_r);
          b_r  <= DW'(s1_r) * DW'(s1_r);
          nn_r <= NNW'(n) * NNW'(n);
          st_r <= S_DIV;
          cnt_r <= '0;
          rem_r <= '0;
          quo_r <= '0;
        end
        S_DIV: begin
          // The first divider cycle loads the dividend 256*D from the products.
          if (cnt_r == '0) begin
            num_r <= (a_r > b_r) ? {a_r - b_r, 8'h00} : '0;
            cnt_r <= cnt_r + 1'b1;
          end else if (cnt_r == CW'(QW + 1)) begin
            st_r <= S_SQ; cnt_r <= '0; x_r <= quo_r; root_r <= '0; srem_r <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            num_r <= num_r << 1;
            if (rem_sh >= {1'b0, nn_r}) begin
              rem_r <= rem_sh - {1'b0, nn_r}; quo_r <= {quo_r[QW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh; quo_r <= {quo_r[QW-2:0], 1'b0};
            end
          end
        end
        S_SQ: begin
          if (cnt_r == CW'(RW)) begin
            st_r <= S_OUT; rms_r <= RmsW'(root_r);
          end else begin
            cnt_r <= cnt_r + 1'b1;
            x_r <= x_r << 2;
            if (srem_sh >= strial) begin
              srem_r <= srem_sh - strial; root_r <= {root_r[RW-2:0], 1'b1};
            end else begin
              srem_r <= srem_sh; root_r <= {root_r[RW-2:0], 1'b0};
            end
          end
        end
        S_OUT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done = (st_r == S_OUT);
  assign rms  = rms_r;
endmodule

// ===== rtl/core/sliding_window_ac_rms_top.sv =====
// ============================================================================
// sliding_window_ac_rms_top
// Two-lane sliding-window AC RMS of voltage and current samples.
// ============================================================================
// Channel | Direction | Payload
// in      | sink      | vin_sample, iin_sample
// out     | source    | v_rms, i_rms, window_full
//
// A result passes through the ring read, the sum update, the products, the
// 50-bit divider and the 25-bit square root, and a hand-over step. Both lanes
// run side by side, and a new input transaction is accepted only once the
// previous result has moved into the output register.
// Reset (rst_n, synchronous) clears position, fill count and sums.
// The output register holds the result while out_ready is low; a new input
// transaction can be accepted meanwhile, but its result waits in the lanes
// until the output register is free.
module sliding_window_ac_rms_top import swr_pkg::*; #(
  parameter int WINDOW      = 200,
  parameter int SAMPLE_BITS = 13
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_vin_sample,
  input  logic [SAMPLE_BITS-1:0] in_iin_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RmsW-1:0]        out_v_rms,
  output logic [RmsW-1:0]        out_i_rms,
  output logic                   out_window_full
);
  localparam int NW  = $clog2(WINDOW + 1);
  localparam int AW  = $clog2(WINDOW);
  localparam int S1W = SAMPLE_BITS + NW;
  localparam int S2W = 2 * SAMPLE_BITS + NW;

  // The samples are registered so they stay stable through the lane pass.
  logic [SAMPLE_BITS-1:0] v_r, i_r;
  logic [AW-1:0]          pos_r;
  logic [NW-1:0]          fill_r;
  logic                   busy_r, rd_r, upd_r;
  logic                   vdone, idone, vdone_r, idone_r;
  logic [RmsW-1:0]        vrms, irms;
  logic [SAMPLE_BITS-1:0] vold, iold;
  logic                   full;
  logic                   take;
  swr_lane_ctl_t          ctl;

  assign full     = (fill_r == NW'(WINDOW));
  assign in_ready = !busy_r;

  // Both lanes have finished and the output register is free or emptying.
  assign take = busy_r && (vdone_r || vdone) && (idone_r || idone) &&
                (!out_valid || out_ready);

  swr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW)) u_vram (
    .clk(clk), .we(rd_r), .addr(pos_r), .wdata(v_r), .rdata(vold));
  swr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW)) u_iram (
    .clk(clk), .we(rd_r), .addr(pos_r), .wdata(i_r), .rdata(iold));

  // The ring read of the oldest entry and its overwrite with the new sample
  // happen in the cycle after accept, as the lanes start.
  assign ctl.start = rd_r;
  assign ctl.full  = full;

  swr_lane #(.SB(SAMPLE_BITS), .NW(NW-1), .S1W(S1W), .S2W(S2W)) u_vlane (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .old_smp(vold), .new_smp(v_r),
    .n(fill_r), .done(vdone), .rms(vrms));
  swr_lane #(.SB(SAMPLE_BITS), .NW(NW-1), .S1W(S1W), .S2W(S2W)) u_ilane (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .old_smp(iold), .new_smp(i_r),
    .n(fill_r), .done(idone), .rms(irms));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; rd_r <= 1'b0; upd_r <= 1'b0; pos_r <= '0; fill_r <= '0;
      out_valid <= 1'b0; vdone_r <= 1'b0; idone_r <= 1'b0;
    end else begin
      rd_r  <= in_valid && in_ready;
      upd_r <= rd_r;
      if (in_valid && in_ready) begin
        v_r <= in_vin_sample; i_r <= in_iin_sample;
      end
      if (rd_r) begin
        pos_r <= (pos_r == AW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
      end
      // Count is bumped once the lanes have latched the update mode.
      if (upd_r && !full) fill_r <= fill_r + 1'b1;
      if (take) begin
        vdone_r <= 1'b0; idone_r <= 1'b0;
      end else begin
        if (vdone) vdone_r <= 1'b1;
        if (idone) idone_r <= 1'b1;
      end
      if (in_valid && in_ready) busy_r <= 1'b1;
      else if (take) busy_r <= 1'b0;
      if (take) begin
        out_valid <= 1'b1; out_v_rms <= vrms; out_i_rms <= irms;
        out_window_full <= full;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/core/swr_checker.sv =====
// ============================================================================
// swr_checker
// Port-level checks of the AC RMS block.
// ============================================================================
`include "sliding_window_ac_rms_top_defines.svh"
module swr_checker import swr_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [RmsW-1:0] out_v_rms,
  input logic [RmsW-1:0] out_i_rms,
  input logic            out_window_full
);
  `SWR_ASSERT_IMPL(a_out_known, out_valid, !$isunknown({out_v_rms, out_i_rms, out_window_full}))
  `SWR_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid)
  `SWR_ASSERT_NEXT(a_out_data_holds, out_valid && !out_ready, $stable({out_v_rms, out_i_rms, out_window_full}))
  `SWR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
endmodule

bind sliding_window_ac_rms_top swr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_v_rms(out_v_rms),
  .out_i_rms(out_i_rms), .out_window_full(out_window_full));

// ===== tb/sliding_window_ac_rms_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// sliding_window_ac_rms_top_tb
// Drives voltage and current sample pairs into the AC RMS block, predicts
// each RMS result from its own ring and sums, and checks every result.
// ============================================================================
module sliding_window_ac_rms_top_tb;
  import swr_pkg::*;

  localparam int WINDOW      = 200;
  localparam int SAMPLE_BITS = 13;
  localparam int SMAX        = (1 << SAMPLE_BITS) - 1;
  localparam int WATCH_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 300;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] vin;
    logic [SAMPLE_BITS-1:0] iin;
  } sample_pair_t;

  typedef struct packed {
    logic [RmsW-1:0] v_rms;
    logic [RmsW-1:0] i_rms;
    logic            full;
  } rms_result_t;

  logic clk;
  logic rst_n;

  swr_if #(.W($bits(sample_pair_t))) in_ch (.clk(clk));
  swr_if #(.W($bits(rms_result_t)))  out_ch (.clk(clk));

  sample_pair_t    in_pair;
  rms_result_t     out_res;
  logic [RmsW-1:0] dut_v_rms, dut_i_rms;
  logic            dut_full;
  assign in_pair = in_ch.data;

  sliding_window_ac_rms_top #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_vin_sample  (in_pair.vin),
    .in_iin_sample  (in_pair.iin),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_v_rms      (dut_v_rms),
    .out_i_rms      (dut_i_rms),
    .out_window_full(dut_full)
  );
  assign out_res     = {dut_v_rms, dut_i_rms, dut_full};
  assign out_ch.data = out_res;

  // The clock runs with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Sample pairs waiting to be offered, and results still owed by the block.
  sample_pair_t sample_q[$];
  rms_result_t  rms_expect_q[$];

  // Own copy of the sliding-window state.
  logic [SAMPLE_BITS-1:0] volt_hist[WINDOW];
  logic [SAMPLE_BITS-1:0] curr_hist[WINDOW];
  int unsigned       wr_idx;
  int unsigned       held;
  longint unsigned   v_s1, v_s2, c_s1, c_s2;

  int  mismatches;
  int  n_in, n_out, n_full;
  int  watch;
  bit  in_took;
  bit  sender_done;
  int  in_idle, out_idle;
  bit  quiet;        // no idling in the last part of the run
  bit  hold_armed;
  int  hold_left;

  // Bit-by-bit integer square root, truncated.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // AC RMS with 4 fractional bits: sqrt(256*(n*S2 - S1^2) / n^2).
  function automatic logic [RmsW-1:0] ac_rms_of(longint unsigned s1, longint unsigned s2,
                                                int unsigned n);
    longint unsigned a, b, nn;
    nn = n;
    a  = nn * s2;
    b  = s1 * s1;
    if (nn == 0 || a <= b) return '0;
    return RmsW'(int_sqrt(((a - b) << 8) / (nn * nn)));
  endfunction

  // Updates the window state with one accepted pair and queues the result.
  task automatic push_window_sample(sample_pair_t p);
    rms_result_t     r;
    longint unsigned ov, oc;
    if (held >= WINDOW) begin
      ov   = volt_hist[wr_idx];
      oc   = curr_hist[wr_idx];
      v_s1 = v_s1 - ov;
      v_s2 = v_s2 - ov * ov;
      c_s1 = c_s1 - oc;
      c_s2 = c_s2 - oc * oc;
    end else begin
      held++;
    end
    volt_hist[wr_idx] = p.vin;
    curr_hist[wr_idx] = p.iin;
    v_s1 = v_s1 + p.vin;
    v_s2 = v_s2 + longint'(p.vin) * longint'(p.vin);
    c_s1 = c_s1 + p.iin;
    c_s2 = c_s2 + longint'(p.iin) * longint'(p.iin);
    wr_idx = (wr_idx + 1) % WINDOW;
    r.v_rms = ac_rms_of(v_s1, v_s2, held);
    r.i_rms = ac_rms_of(c_s1, c_s2, held);
    r.full  = (held >= WINDOW);
    rms_expect_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("ERROR result %0d: %s got %0d expected %0d", n_out, what, got, want);
  endtask

  // Driver: input changes at the falling edge. A transaction accepted at the
  // last rising edge is flagged by in_took, so the next pair can replace it
  // with a single assignment and valid need not drop in between.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      in_idle     <= 0;
    end else if (!in_ch.valid || in_took) begin
      if (in_idle > 0) begin
        in_idle     <= in_idle - 1;
        in_ch.valid <= 1'b0;
      end else if (sample_q.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
        in_idle     <= $urandom_range(0, 5);
        in_ch.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_ch.data  <= sample_q.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: bursts of back-pressure, plus one long hold-off that lets the
  // block fill up while the driver keeps offering pairs.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_idle     <= 0;
      hold_left    <= 0;
    end else if (hold_armed && hold_left == 0 && n_in == 300) begin
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else if (hold_left == 1) begin
      hold_left    <= 0;
      out_ch.ready <= 1'b1;
    end else if (out_idle > 0) begin
      out_idle     <= out_idle - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_idle     <= $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Clear the hold-off request once it has started, so it happens once.
  always @(posedge clk) begin
    if (hold_left == HOLD_CYCLES) hold_armed <= 1'b0;
  end

  // Monitor: both channels sampled at the rising edge.
  always @(posedge clk) begin
    rms_result_t e;
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        push_window_sample(in_pair);
        n_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (out_res.full) n_full++;
        if (rms_expect_q.size() == 0) begin
          report_mismatch("unexpected result, v_rms", out_res.v_rms, 0);
        end else begin
          e = rms_expect_q.pop_front();
          if (out_res.v_rms !== e.v_rms) report_mismatch("v_rms", out_res.v_rms, e.v_rms);
          if (out_res.i_rms !== e.i_rms) report_mismatch("i_rms", out_res.i_rms, e.i_rms);
          if (out_res.full !== e.full)
            report_mismatch("window_full", out_res.full, e.full);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction happens on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      watch <= 0;
    end else if (!sender_done || rms_expect_q.size() > 0 || sample_q.size() > 0) begin
      watch <= watch + 1;
      if (watch + 1 >= WATCH_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCH_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic sample_pair_t mk_pair(int v, int c);
    sample_pair_t p;
    p.vin = v[SAMPLE_BITS-1:0];
    p.iin = c[SAMPLE_BITS-1:0];
    return p;
  endfunction

  // Random sample around a DC level with a chosen swing, clipped to range.
  function automatic int near_dc(int dc, int swing);
    int x;
    x = dc + $urandom_range(0, 2 * swing) - swing;
    if (x < 0) x = 0;
    if (x > SMAX) x = SMAX;
    return x;
  endfunction

  initial begin
    int kind, dc_v, dc_c, sw_v, sw_c;
    rst_n       = 1'b0;
    in_took     = 1'b0;
    sender_done = 1'b0;
    quiet       = 1'b0;
    hold_armed  = 1'b1;
    mismatches  = 0;
    n_in = 0; n_out = 0; n_full = 0; watch = 0;
    wr_idx = 0; held = 0;
    v_s1 = 0; v_s2 = 0; c_s1 = 0; c_s2 = 0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: the first sample alone, constant extremes, full-scale square
    // wave, and single-bit patterns so every input bit toggles.
    sample_q.push_back(mk_pair(0, SMAX));
    sample_q.push_back(mk_pair(SMAX, 0));
    sample_q.push_back(mk_pair(SMAX, 0));
    sample_q.push_back(mk_pair(0, SMAX));
    sample_q.push_back(mk_pair(SMAX, SMAX));
    sample_q.push_back(mk_pair(0, 0));
    for (int i = 0; i < SAMPLE_BITS; i++) sample_q.push_back(mk_pair(1 << i, SMAX ^ (1 << i)));
    sample_q.push_back(mk_pair(SMAX / 2, SMAX / 2 + 1));
    sample_q.push_back(mk_pair(1, SMAX - 1));

    // The sender pauses here until every owed result has arrived.
    wait (sample_q.size() == 0 && !in_ch.valid && rms_expect_q.size() == 0);
    repeat (5) @(posedge clk);

    // Random: mostly signal-like bursts around a DC level, some full-range
    // noise and extremes. 750 pairs wrap the window several times.
    for (int i = 0; i < 750; i++) begin
      if (i % 40 == 0) begin
        dc_v = $urandom_range(0, SMAX);
        dc_c = $urandom_range(0, SMAX);
        sw_v = $urandom_range(0, 4) == 0 ? SMAX : $urandom_range(0, 600);
        sw_c = $urandom_range(0, 4) == 0 ? SMAX : $urandom_range(0, 600);
      end
      kind = $urandom_range(0, 9);
      if (kind < 7)
        sample_q.push_back(mk_pair(near_dc(dc_v, sw_v), near_dc(dc_c, sw_c)));
      else if (kind < 9)
        sample_q.push_back(mk_pair($urandom_range(0, SMAX), $urandom_range(0, SMAX)));
      else
        sample_q.push_back(mk_pair($urandom_range(0, 1) * SMAX, $urandom_range(0, 1) * SMAX));
    end

    // Idling stops for the last stretch of pairs.
    wait (sample_q.size() < 100);
    quiet = 1'b1;
    wait (sample_q.size() == 0 && !in_ch.valid);
    sender_done = 1'b1;
    wait (rms_expect_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d sample pairs and %0d results, %0d with a full window.",
             n_in, n_out, n_full);
    if (mismatches == 0 && rms_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/swr_pkg.sv
rtl/core/swr_if.sv
rtl/core/swr_ram.sv
rtl/core/swr_lane.sv
rtl/core/sliding_window_ac_rms_top.sv
rtl/core/swr_checker.sv
tb/sliding_window_ac_rms_top_tb.sv
